// ===== hw/rtl/cmt_pkg.sv =====
// ---------------------------------------------------------------------------
// cmt_pkg
// Shared types and constants for the consist member table.
// ---------------------------------------------------------------------------
package cmt_pkg;

    localparam int ID_W        = 48;
    localparam int FLAG_W      = 8;
    localparam int POS_W       = 8;
    localparam int IDX_W       = 8;
    localparam int CNT_W       = 8;
    localparam int COUNT_OUT_W = 4;
    localparam int COUNT_MAX   = 15;

    typedef enum logic [1:0] {
        KIND_ATTACH  = 2'd0,
        KIND_DETACH  = 2'd1,
        KIND_COUNT   = 2'd2,
        KIND_INDEXED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXISTS    = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic [ID_W-1:0]     target;
        logic [FLAG_W-1:0]   flags;
        logic [POS_W-1:0]    pos;
        logic [CNT_W-1:0]    seen;
        logic                match_hit;
        logic [IDX_W-1:0]    match_idx;
        logic                empty_hit;
        logic [IDX_W-1:0]    empty_idx;
        logic                nth_hit;
        logic [ID_W-1:0]     nth_id;
        logic [FLAG_W-1:0]   nth_flags;
    } ctx_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [ID_W-1:0]     id;
        logic [FLAG_W-1:0]   flags;
    } wr_t;

    typedef struct packed {
        status_t                 status;
        logic [COUNT_OUT_W-1:0]  member_count;
        logic                    entry_valid;
        logic [POS_W-1:0]        entry_position;
        logic [FLAG_W-1:0]       entry_flags;
        logic [ID_W-1:0]         entry_node_id;
    } rsp_t;

endpackage

// ===== hw/rtl/cmt_if.sv =====
// ---------------------------------------------------------------------------
// cmt_if
// Request, response and configuration channels of the consist member table.
// ---------------------------------------------------------------------------
interface cmt_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [cmt_pkg::ID_W-1:0] target_node_id;
    logic [7:0]               member_flags;
    logic [7:0]               query_position;

    modport source (output valid, kind, target_node_id, member_flags, query_position,
                    input ready);
    modport sink   (input valid, kind, target_node_id, member_flags, query_position,
                    output ready);
endinterface

interface cmt_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [3:0]               member_count;
    logic                     entry_valid;
    logic [7:0]               entry_position;
    logic [7:0]               entry_flags;
    logic [cmt_pkg::ID_W-1:0] entry_node_id;

    modport source (output valid, status, member_count, entry_valid, entry_position,
                    entry_flags, entry_node_id, input ready);
    modport sink   (input valid, status, member_count, entry_valid, entry_position,
                    entry_flags, entry_node_id, output ready);
endinterface

interface cmt_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [cmt_pkg::ID_W-1:0] own_node_id;

    modport source (output valid, own_node_id, input ready);
    modport sink   (input valid, own_node_id, output ready);
endinterface

// ===== hw/rtl/consist_member_table.sv =====
// The scan context walks the row of slot cells one cell per cycle, and one request is
// in flight at a time.
// A finished response waits in its output register while the next request is taken.
// Reset (rst_n low, asynchronous): every slot empty, own node ID zero, no response.
// ---------------------------------------------------------------------------
// consist_member_table
// Fixed table of consist members, scanned by a context passed along a row of
// slot cells; attach, detach, count and indexed query requests.
// ---------------------------------------------------------------------------
module consist_member_table #(
    parameter int TABLE_SLOTS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    cmt_req_if.sink   req,
    cmt_rsp_if.source rsp,
    cmt_cfg_if.sink   cfg
);
    import cmt_pkg::*;

    logic [ID_W-1:0] own_reg;
    ctx_t            chain [0:TABLE_SLOTS];
    wr_t             wr;
    rsp_t            rsp_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg <= '0;
        end
        else if (cfg.valid)
        begin
            own_reg <= cfg.own_node_id;
        end
    end

    cmt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_kind    (req.kind),
        .req_target  (req.target_node_id),
        .req_flags   (req.member_flags),
        .req_pos     (req.query_position),
        .own_node_id (own_reg),
        .tail        (chain[TABLE_SLOTS]),
        .head        (chain[0]),
        .wr          (wr),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp         (rsp_data)
    );

    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        cmt_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctx_in  (chain[i]),
            .wr      (wr),
            .ctx_out (chain[i+1])
        );
    end

    assign rsp.status         = rsp_data.status;
    assign rsp.member_count   = rsp_data.member_count;
    assign rsp.entry_valid    = rsp_data.entry_valid;
    assign rsp.entry_position = rsp_data.entry_position;
    assign rsp.entry_flags    = rsp_data.entry_flags;
    assign rsp.entry_node_id  = rsp_data.entry_node_id;

endmodule

// ===== hw/rtl/cmt_cell.sv =====
// ---------------------------------------------------------------------------
// cmt_cell
// One table slot: holds a member ID and flag byte, folds its slot into the
// passing scan context and registers the context for the next cell.
// ---------------------------------------------------------------------------
module cmt_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cmt_pkg::ctx_t ctx_in,
    input  cmt_pkg::wr_t  wr,
    output cmt_pkg::ctx_t ctx_out
);
    import cmt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ID_W-1:0]   id_reg;
    logic [FLAG_W-1:0] flags_reg;
    ctx_t              ctx_reg;
    ctx_t              ctx_next;
    logic              occupied;

    assign occupied = (id_reg != '0);

    always_comb
    begin
        ctx_next = ctx_in;
        if (!ctx_in.match_hit && (id_reg == ctx_in.target))
        begin
            ctx_next.match_hit = 1'b1;
            ctx_next.match_idx = MY_IDX;
        end
        if (!ctx_in.empty_hit && !occupied)
        begin
            ctx_next.empty_hit = 1'b1;
            ctx_next.empty_idx = MY_IDX;
        end
        if (occupied && !ctx_in.nth_hit && (ctx_in.seen == ctx_in.pos))
        begin
            ctx_next.nth_hit   = 1'b1;
            ctx_next.nth_id    = id_reg;
            ctx_next.nth_flags = flags_reg;
        end
        if (occupied)
        begin
            ctx_next.seen = ctx_in.seen + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg    <= '0;
            flags_reg <= '0;
            ctx_reg   <= '0;
        end
        else
        begin
            ctx_reg <= ctx_next;
            if (wr.en && (wr.idx == MY_IDX))
            begin
                id_reg    <= wr.id;
                flags_reg <= wr.flags;
            end
        end
    end

    assign ctx_out = ctx_reg;

endmodule

// ===== hw/rtl/cmt_ctrl.sv =====
// ---------------------------------------------------------------------------
// cmt_ctrl
// Request sequencer: launches a scan context into the cell row, decides the
// table update from the context at the tail and holds the response.
// ---------------------------------------------------------------------------
module cmt_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [1:0]                 req_kind,
    input  logic [cmt_pkg::ID_W-1:0]   req_target,
    input  logic [cmt_pkg::FLAG_W-1:0] req_flags,
    input  logic [cmt_pkg::POS_W-1:0]  req_pos,
    input  logic [cmt_pkg::ID_W-1:0]   own_node_id,
    input  cmt_pkg::ctx_t              tail,
    output cmt_pkg::ctx_t              head,
    output cmt_pkg::wr_t               wr,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output cmt_pkg::rsp_t              rsp
);
    import cmt_pkg::*;

    state_t state_reg;
    state_t state_next;
    ctx_t   head_reg;
    ctx_t   head_next;
    rsp_t   hold_reg;
    rsp_t   hold_next;
    rsp_t   out_reg;
    rsp_t   out_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    rsp_t   res_calc;
    wr_t    wr_calc;
    logic   out_free;

    always_comb
    begin
        logic             insert;
        logic             remove;
        logic [CNT_W-1:0] cnt_sum;
        res_calc = '0;
        wr_calc  = '0;
        insert   = 1'b0;
        remove   = 1'b0;
        unique case (tail.kind)
            KIND_ATTACH:
            begin
                res_calc.entry_node_id = tail.target;
                if (tail.target == own_node_id)
                begin
                    res_calc.status = ST_EXISTS;
                end
                else if (tail.target != '0)
                begin
                    if (tail.match_hit)
                    begin
                        wr_calc.en    = 1'b1;
                        wr_calc.idx   = tail.match_idx;
                        wr_calc.id    = tail.target;
                        wr_calc.flags = tail.flags;
                    end
                    else if (tail.empty_hit)
                    begin
                        wr_calc.en    = 1'b1;
                        wr_calc.idx   = tail.empty_idx;
                        wr_calc.id    = tail.target;
                        wr_calc.flags = tail.flags;
                        insert        = 1'b1;
                    end
                    else
                    begin
                        res_calc.status = ST_EXISTS;
                    end
                end
            end
            KIND_DETACH:
            begin
                res_calc.entry_node_id = tail.target;
                if (tail.target != '0)
                begin
                    if (tail.match_hit)
                    begin
                        wr_calc.en  = 1'b1;
                        wr_calc.idx = tail.match_idx;
                        remove      = 1'b1;
                    end
                    else
                    begin
                        res_calc.status = ST_NOT_FOUND;
                    end
                end
            end
            KIND_COUNT:
            begin
            end
            KIND_INDEXED:
            begin
                res_calc.entry_position = tail.pos;
                if (tail.nth_hit)
                begin
                    res_calc.entry_valid   = 1'b1;
                    res_calc.entry_flags   = tail.nth_flags;
                    res_calc.entry_node_id = tail.nth_id;
                end
            end
            default:
            begin
            end
        endcase
        cnt_sum = tail.seen + CNT_W'(insert) - CNT_W'(remove);
        res_calc.member_count = (cnt_sum > CNT_W'(COUNT_MAX)) ?
                                COUNT_OUT_W'(COUNT_MAX) : cnt_sum[COUNT_OUT_W-1:0];
    end

    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        head_next      = '0;
        hold_next      = hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr             = '0;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    head_next.valid  = 1'b1;
                    head_next.kind   = kind_t'(req_kind);
                    head_next.target = req_target;
                    head_next.flags  = req_flags;
                    head_next.pos    = req_pos;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    wr = wr_calc;
                    if (out_free)
                    begin
                        out_next       = res_calc;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        hold_next  = res_calc;
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign head      = head_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== hw/rtl/cmt_checker.sv =====
// ---------------------------------------------------------------------------
// cmt_checker
// Port-level checks for the consist member table, bound to the top level.
// ---------------------------------------------------------------------------
module cmt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [1:0]                 rsp_status,
    input logic                       rsp_entry_valid,
    input logic [cmt_pkg::FLAG_W-1:0] rsp_entry_flags,
    input logic [cmt_pkg::ID_W-1:0]   rsp_entry_node_id
);
    import cmt_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_entry_node_id))
        else $error("response dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    a_miss_flags_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_entry_valid |-> rsp_entry_flags == '0)
        else $error("flags reported without a found entry");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_entry_valid |-> rsp_entry_node_id != '0
                                         && rsp_status == ST_OK)
        else $error("found entry is empty or not ok");

endmodule

bind consist_member_table cmt_checker u_cmt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_entry_valid   (rsp.entry_valid),
    .rsp_entry_flags   (rsp.entry_flags),
    .rsp_entry_node_id (rsp.entry_node_id)
);

// ===== test/consist_member_table_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// consist_member_table_test
// Self-checking bench for the consist member table: a directed table of
// requests around empty, full and refused cases, then random phases under
// different own node IDs, each reply checked against a table predictor or a pinned reply.
// ---------------------------------------------------------------------------
module consist_member_table_test;

    import cmt_pkg::*;

    localparam int TABLE_SLOTS = 8;
    localparam int SETTLE      = 4 * TABLE_SLOTS;
    localparam int PHASE_ITEMS = 250;
    localparam int POOL_SIZE   = 12;
    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    typedef struct {
        bit              is_cfg;
        kind_t           kind;
        logic [ID_W-1:0] id;
        logic [7:0]      flags;
        logic [7:0]      pos;
        bit              pinned;
        rsp_t            reply;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    cmt_req_if req_ch ();
    cmt_rsp_if rsp_ch ();
    cmt_cfg_if cfg_ch ();

    consist_member_table #(.TABLE_SLOTS(TABLE_SLOTS)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #2 clk = ~clk;

    logic [ID_W-1:0]   member_ids [TABLE_SLOTS];
    logic [FLAG_W-1:0] member_flag_bytes [TABLE_SLOTS];
    logic [ID_W-1:0]   own_id_model;

    rsp_t expected_replies [$];
    rsp_t oldest_reply;
    rsp_t fresh_reply;
    rsp_t seen_reply;
    int   mismatches = 0;

    bit   req_pinned;
    rsp_t req_pin;
    bit   steady = 1'b0;
    bit   stall_request = 1'b0;
    int   hold_left = 0;

    stim_row_t directed_rows [$];

    function automatic int find_slot(logic [ID_W-1:0] id);
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (member_ids[i] == id)
                return i;
        end
        return TABLE_SLOTS;
    endfunction

    function automatic rsp_t predict_member_op(kind_t k, logic [ID_W-1:0] id,
                                               logic [7:0] fl, logic [7:0] pos);
        rsp_t r;
        int   hit;
        int   seen;
        int   occupied;
        r = '0;
        r.status = ST_OK;
        case (k)
            KIND_ATTACH:
            begin
                r.entry_node_id = id;
                if (id == own_id_model)
                    r.status = ST_EXISTS;
                else if (id != '0)
                begin
                    hit = find_slot(id);
                    if (hit < TABLE_SLOTS)
                        member_flag_bytes[hit] = fl;
                    else
                    begin
                        hit = find_slot('0);
                        if (hit < TABLE_SLOTS)
                        begin
                            member_ids[hit] = id;
                            member_flag_bytes[hit] = fl;
                        end
                        else
                            r.status = ST_EXISTS;
                    end
                end
            end
            KIND_DETACH:
            begin
                r.entry_node_id = id;
                if (id != '0)
                begin
                    hit = find_slot(id);
                    if (hit < TABLE_SLOTS)
                    begin
                        member_ids[hit] = '0;
                        member_flag_bytes[hit] = '0;
                    end
                    else
                        r.status = ST_NOT_FOUND;
                end
            end
            KIND_INDEXED:
            begin
                r.entry_position = pos;
                seen = 0;
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (member_ids[i] != '0)
                    begin
                        if (seen == pos && !r.entry_valid)
                        begin
                            r.entry_valid = 1'b1;
                            r.entry_flags = member_flag_bytes[i];
                            r.entry_node_id = member_ids[i];
                        end
                        seen++;
                    end
                end
            end
            default: ;
        endcase
        occupied = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (member_ids[i] != '0)
                occupied++;
        end
        if (occupied > COUNT_MAX)
            occupied = COUNT_MAX;
        r.member_count = occupied[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic rsp_t mk_reply(status_t st, int cnt, bit v, logic [7:0] pos,
                                      logic [7:0] fl, logic [ID_W-1:0] id);
        rsp_t r;
        r.status = st;
        r.member_count = cnt[COUNT_OUT_W-1:0];
        r.entry_valid = v;
        r.entry_position = pos;
        r.entry_flags = fl;
        r.entry_node_id = id;
        return r;
    endfunction

    function automatic stim_row_t mk_row(kind_t k, logic [ID_W-1:0] id, logic [7:0] fl,
                                         logic [7:0] pos, bit pinned, rsp_t reply);
        stim_row_t s;
        s.is_cfg = 1'b0;
        s.kind = k;
        s.id = id;
        s.flags = fl;
        s.pos = pos;
        s.pinned = pinned;
        s.reply = reply;
        return s;
    endfunction

    function automatic stim_row_t mk_cfg_row(logic [ID_W-1:0] own);
        stim_row_t s;
        s = mk_row(KIND_COUNT, own, '0, '0, 1'b0, '0);
        s.is_cfg = 1'b1;
        return s;
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[ID_W-1:0];
    endfunction

    // request / reply / register monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen_reply.status = status_t'(rsp_ch.status);
                seen_reply.member_count = rsp_ch.member_count;
                seen_reply.entry_valid = rsp_ch.entry_valid;
                seen_reply.entry_position = rsp_ch.entry_position;
                seen_reply.entry_flags = rsp_ch.entry_flags;
                seen_reply.entry_node_id = rsp_ch.entry_node_id;
                if (expected_replies.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: reply with no request waiting: %p", $realtime, seen_reply);
                    mismatches++;
                end
                else
                begin
                    oldest_reply = expected_replies.pop_front();
                    if (seen_reply.status !== oldest_reply.status
                        || seen_reply.member_count !== oldest_reply.member_count
                        || seen_reply.entry_valid !== oldest_reply.entry_valid
                        || seen_reply.entry_position !== oldest_reply.entry_position
                        || seen_reply.entry_flags !== oldest_reply.entry_flags
                        || seen_reply.entry_node_id !== oldest_reply.entry_node_id)
                    begin
                        if (mismatches < 10)
                            $display("%0t: reply mismatch\n  expected %p\n  actual   %p",
                                     $realtime, oldest_reply, seen_reply);
                        mismatches++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                own_id_model = cfg_ch.own_node_id;
            if (req_ch.valid && req_ch.ready)
            begin
                fresh_reply = predict_member_op(kind_t'(req_ch.kind), req_ch.target_node_id,
                                                req_ch.member_flags, req_ch.query_position);
                if (req_pinned)
                    fresh_reply = req_pin;
                expected_replies.push_back(fresh_reply);
            end
        end
    end

    // reply side: random backpressure plus long holds on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    initial
    begin
        #2_000_000;
        $display("consist_member_table regression: fail");
        $finish;
    end

    task automatic send_request(kind_t k, logic [ID_W-1:0] id, logic [7:0] fl,
                                logic [7:0] pos, bit pinned, rsp_t reply);
        while (!steady && $urandom_range(99) < 14)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.kind <= k;
        req_ch.target_node_id <= id;
        req_ch.member_flags <= fl;
        req_ch.query_position <= pos;
        req_pinned <= pinned;
        req_pin <= reply;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_own_id(logic [ID_W-1:0] own);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.own_node_id <= own;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [ID_W-1:0] id_pool [POOL_SIZE];
        logic [ID_W-1:0] own_setting;
        logic [ID_W-1:0] pick_id;
        logic [7:0]      pick_pos;
        kind_t           pick_kind;
        int              roll;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_ATTACH;
        req_ch.target_node_id = '0;
        req_ch.member_flags = '0;
        req_ch.query_position = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.own_node_id = '0;
        req_pinned = 1'b0;
        req_pin = '0;
        own_id_model = '0;
        own_setting = '0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            member_ids[i] = '0;
            member_flag_bytes[i] = '0;
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        directed_rows.push_back(mk_row(KIND_COUNT, '0, '0, 8'd0, 1'b1,
                                       mk_reply(ST_OK, 0, 1'b0, 8'd0, 8'd0, '0)));
        directed_rows.push_back(mk_row(KIND_INDEXED, '0, '0, 8'd0, 1'b1,
                                       mk_reply(ST_OK, 0, 1'b0, 8'd0, 8'd0, '0)));
        directed_rows.push_back(mk_row(KIND_INDEXED, ID_MAX, 8'hFF, 8'd255, 1'b1,
                                       mk_reply(ST_OK, 0, 1'b0, 8'd255, 8'd0, '0)));
        directed_rows.push_back(mk_row(KIND_ATTACH, '0, 8'hFF, 8'd0, 1'b1,
                                       mk_reply(ST_EXISTS, 0, 1'b0, 8'd0, 8'd0, '0)));
        directed_rows.push_back(mk_row(KIND_DETACH, '0, 8'h00, 8'd0, 1'b1,
                                       mk_reply(ST_OK, 0, 1'b0, 8'd0, 8'd0, '0)));
        directed_rows.push_back(mk_row(KIND_DETACH, 48'h123, 8'h00, 8'd0, 1'b1,
                                       mk_reply(ST_NOT_FOUND, 0, 1'b0, 8'd0, 8'd0,
                                                48'h123)));
        directed_rows.push_back(mk_cfg_row(ID_MAX));
        directed_rows.push_back(mk_row(KIND_ATTACH, '0, 8'h5A, 8'd0, 1'b1,
                                       mk_reply(ST_OK, 0, 1'b0, 8'd0, 8'd0, '0)));
        directed_rows.push_back(mk_row(KIND_ATTACH, ID_MAX, 8'h11, 8'd0, 1'b1,
                                       mk_reply(ST_EXISTS, 0, 1'b0, 8'd0, 8'd0, ID_MAX)));
        directed_rows.push_back(mk_row(KIND_ATTACH, 48'h1, 8'h00, 8'd0, 1'b0, '0));
        directed_rows.push_back(mk_row(KIND_ATTACH, ID_MAX - 1, 8'hFF, 8'd0, 1'b0, '0));
        directed_rows.push_back(mk_row(KIND_ATTACH, 48'h8000_0000_0000, 8'h80, 8'd0, 1'b0,
                                       '0));
        directed_rows.push_back(mk_row(KIND_ATTACH, 48'h5555_5555_5555, 8'h55, 8'd0, 1'b0,
                                       '0));
        directed_rows.push_back(mk_row(KIND_ATTACH, 48'hAAAA_AAAA_AAAA, 8'hAA, 8'd0, 1'b0,
                                       '0));
        directed_rows.push_back(mk_row(KIND_ATTACH, 48'h0000_0001_0000, 8'h01, 8'd0, 1'b0,
                                       '0));
        directed_rows.push_back(mk_row(KIND_ATTACH, 48'h7FFF_FFFF_FFFF, 8'h7F, 8'd0, 1'b0,
                                       '0));
        directed_rows.push_back(mk_row(KIND_ATTACH, 48'h0123_4567_89AB, 8'hC3, 8'd0, 1'b0,
                                       '0));
        directed_rows.push_back(mk_row(KIND_ATTACH, 48'hDEAD_BEEF_0001, 8'h99, 8'd0, 1'b1,
                                       mk_reply(ST_EXISTS, 8, 1'b0, 8'd0, 8'd0,
                                                48'hDEAD_BEEF_0001)));
        directed_rows.push_back(mk_row(KIND_ATTACH, 48'h5555_5555_5555, 8'h3C, 8'd0, 1'b0,
                                       '0));
        directed_rows.push_back(mk_row(KIND_ATTACH, '0, 8'hFF, 8'd0, 1'b1,
                                       mk_reply(ST_OK, 8, 1'b0, 8'd0, 8'd0, '0)));
        directed_rows.push_back(mk_row(KIND_INDEXED, '0, '0, 8'd7, 1'b0, '0));
        directed_rows.push_back(mk_row(KIND_INDEXED, '0, '0, 8'd8, 1'b1,
                                       mk_reply(ST_OK, 8, 1'b0, 8'd8, 8'd0, '0)));
        directed_rows.push_back(mk_row(KIND_DETACH, 48'h8000_0000_0000, 8'h00, 8'd0, 1'b0,
                                       '0));
        directed_rows.push_back(mk_row(KIND_INDEXED, '0, '0, 8'd2, 1'b0, '0));
        directed_rows.push_back(mk_row(KIND_ATTACH, 48'hDEAD_BEEF_0001, 8'h99, 8'd0, 1'b0,
                                       '0));
        directed_rows.push_back(mk_row(KIND_COUNT, '0, '0, 8'd0, 1'b1,
                                       mk_reply(ST_OK, 8, 1'b0, 8'd0, 8'd0, '0)));
        directed_rows.push_back(mk_row(KIND_DETACH, 48'h2, 8'h00, 8'd0, 1'b1,
                                       mk_reply(ST_NOT_FOUND, 8, 1'b0, 8'd0, 8'd0, 48'h2)));

        foreach (directed_rows[n])
        begin
            if (directed_rows[n].is_cfg)
            begin
                drain();
                write_own_id(directed_rows[n].id);
                own_setting = directed_rows[n].id;
            end
            else
                send_request(directed_rows[n].kind, directed_rows[n].id,
                             directed_rows[n].flags, directed_rows[n].pos,
                             directed_rows[n].pinned, directed_rows[n].reply);
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            for (int i = 0; i < POOL_SIZE; i++)
                id_pool[i] = random_id();
            id_pool[POOL_SIZE-1] = ID_MAX;
            id_pool[POOL_SIZE-2] = 48'h1;
            case (phase)
                0: own_setting = '0;
                1: own_setting = ID_MAX;
                3: own_setting = id_pool[0];
                4: own_setting = 48'h1;
                default: own_setting = random_id();
            endcase
            write_own_id(own_setting);
            steady = (phase == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 6)
                    pick_id = '0;
                else if (roll < 12)
                    pick_id = own_setting;
                else if (roll < 18)
                    pick_id = random_id();
                else
                    pick_id = id_pool[$urandom_range(POOL_SIZE-1)];
                roll = $urandom_range(99);
                if (roll < 38)
                    pick_kind = KIND_ATTACH;
                else if (roll < 68)
                    pick_kind = KIND_DETACH;
                else if (roll < 78)
                    pick_kind = KIND_COUNT;
                else
                    pick_kind = KIND_INDEXED;
                if ($urandom_range(3) == 0)
                    pick_pos = 8'($urandom_range(255));
                else
                    pick_pos = 8'($urandom_range(9));
                send_request(pick_kind, pick_id, 8'($urandom_range(255)), pick_pos, 1'b0,
                             '0);
                if (phase == 2 && n == 60)
                    stall_request = 1'b1;
                if (phase == 3 && n == 120)
                    drain();
            end
        end

        drain();
        steady = 1'b0;
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("consist_member_table regression: pass");
        else
            $display("consist_member_table regression: fail");
        $finish;
    end

endmodule
